### hw/rtl/alsp_pkg.sv
// ----------------------------------------------------------------------------
// alsp_pkg
// Shared types and constants for the allocation size live/peak table:
// channel payloads, slot record layout, and controller/datapath interface.
// ----------------------------------------------------------------------------
`default_nettype none

package alsp_pkg;

    // Default number of distinct sizes the table can hold
    localparam int TABLE_SLOTS_DEF = 64;

    localparam int SIZE_W  = 24;
    localparam int TOTAL_W = 24;
    localparam int LIVE_W  = 16;
    localparam int PEAK_W  = 15;

    localparam logic [TOTAL_W-1:0]       TOTAL_MAX = '1;
    localparam logic signed [LIVE_W-1:0] LIVE_MAX  = 16'sh7FFF;
    localparam logic signed [LIVE_W-1:0] LIVE_MIN  = 16'sh8000;

    // Input event
    typedef struct packed {
        logic              is_alloc;
        logic [SIZE_W-1:0] req_size;
    } t_in;

    // Per-event result
    typedef struct packed {
        logic [TOTAL_W-1:0]       entry_alloc_total;
        logic signed [LIVE_W-1:0] entry_live;
        logic [PEAK_W-1:0]        entry_peak;
        logic                     entry_created;
        logic                     table_full;
    } t_out;

    // One stored table slot
    typedef struct packed {
        logic [SIZE_W-1:0]        size;
        logic [TOTAL_W-1:0]       total;
        logic signed [LIVE_W-1:0] live;
        logic [PEAK_W-1:0]        peak;
    } t_slot;

    // Controller to datapath commands
    typedef struct packed {
        logic load;     // capture event, rewind scan index
        logic rd;       // read slot at scan index
        logic idx_inc;  // advance scan index
        logic hit;      // scan found the size at scan index
        logic finish;   // update/create slot and load result
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic fill_zero;  // no slot in use
        logic match;      // read slot holds the event's size
        logic last;       // scan index is the last used slot
        logic out_free;   // result register can take a new result
    } t_sts;

endpackage : alsp_pkg

`default_nettype wire

### hw/rtl/alloc_size_live_peak_table.sv
// ----------------------------------------------------------------------------
// alloc_size_live_peak_table
// Per-size allocation statistics with high-water mark.
//
// Input channel (i_in_valid/o_in_ready/i_in_data) carries alloc/free events
// with a request size. Output channel (o_out_valid/i_out_ready/o_out_data)
// returns exactly one result per event: the slot's updated alloc total, live
// count and peak, a created flag, or a table-full flag with zero counters.
//
// One event is handled at a time. Slots are kept in a RAM with registered
// read and are searched in fill order, each slot in a read step and then a
// compare step. A hit ends the scan at its slot; a new size is known only
// once all used slots are scanned, and an empty table is not scanned at all.
// o_in_ready rises as the result is loaded, so the next transfer can follow
// straight after; an event holds the input until its result is loaded.
// Reset empties the table by clearing the fill count; no clearing pass.
// Reset also drops a pending result.
// A stalled receiver holds the result register; a finished event then
// waits in the last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module alloc_size_live_peak_table
    import alsp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    alsp_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    // Table storage and update
    alsp_datapath #(
        .TABLE_SLOTS(TABLE_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule : alloc_size_live_peak_table

`default_nettype wire

### hw/rtl/alsp_ram.sv
// ----------------------------------------------------------------------------
// alsp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : alsp_ram

`default_nettype wire

### hw/rtl/alsp_datapath.sv
// ----------------------------------------------------------------------------
// alsp_datapath
// Event registers, scan index, fill count, slot RAM, counter update
// arithmetic and the result register with its output handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_datapath
    import alsp_pkg::*;
#(
    parameter int TABLE_SLOTS = TABLE_SLOTS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_in  i_in_data,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_out      o_out_data
);

    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(TABLE_SLOTS);

    logic              r_is_alloc;
    logic [SIZE_W-1:0] r_size;
    logic [IDX_W-1:0]  r_idx;
    logic [CNT_W-1:0]  r_fill;
    logic              r_out_valid;
    t_out              r_out;

    t_slot             rd_slot;
    t_slot             base;
    t_slot             upd;
    logic              full;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    t_out              n_out;

    // Slot storage
    alsp_ram #(
        .WIDTH($bits(t_slot)),
        .DEPTH(TABLE_SLOTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(upd),
        .i_re   (i_cmd.rd),
        .i_raddr(r_idx),
        .o_rdata(rd_slot)
    );

    // Capture event and step scan index
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_is_alloc <= i_in_data.is_alloc;
            r_size     <= i_in_data.req_size;
            r_idx      <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // Start from stored counters on a hit, from zero for a new slot
    always_comb begin
        base      = '0;
        base.size = r_size;
        if (i_cmd.hit) begin
            base.total = rd_slot.total;
            base.live  = rd_slot.live;
            base.peak  = rd_slot.peak;
        end
    end

    // Saturating counter update
    always_comb begin
        upd = base;
        if (r_is_alloc) begin
            if (base.total != TOTAL_MAX) begin
                upd.total = base.total + TOTAL_W'(1);
            end
            if (base.live != LIVE_MAX) begin
                upd.live = base.live + 16'sd1;
            end
            if (!upd.live[LIVE_W-1] && (upd.live[PEAK_W-1:0] > base.peak)) begin
                upd.peak = upd.live[PEAK_W-1:0];
            end
        end else begin
            if (base.live != LIVE_MIN) begin
                upd.live = base.live - 16'sd1;
            end
        end
    end

    assign full  = !i_cmd.hit && (r_fill == FILL_MAX);
    assign we    = i_cmd.finish && !full;
    assign waddr = i_cmd.hit ? r_idx : r_fill[IDX_W-1:0];

    // Allocate slots in order; they are never released
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_cmd.finish && !i_cmd.hit && !full) begin
            r_fill <= r_fill + CNT_W'(1);
        end
    end

    // Form the result
    always_comb begin
        n_out = '0;
        if (full) begin
            n_out.table_full = 1'b1;
        end else begin
            n_out.entry_alloc_total = upd.total;
            n_out.entry_live        = upd.live;
            n_out.entry_peak        = upd.peak;
            n_out.entry_created     = !i_cmd.hit;
        end
    end

    // Result register, held until the transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_sts.fill_zero = (r_fill == '0);
    assign o_sts.match     = (rd_slot.size == r_size);
    assign o_sts.last      = ((CNT_W'(r_idx) + CNT_W'(1)) == r_fill);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule : alsp_datapath

`default_nettype wire

### hw/rtl/alsp_ctrl.sv
// ----------------------------------------------------------------------------
// alsp_ctrl
// Controller: accepts one event, sequences the slot scan over the RAM and
// hands the hit/miss decision to the datapath for the final update.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_ctrl
    import alsp_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_CMP  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_hit, n_hit;

    // Next state
    always_comb begin
        n_state = r_state;
        n_hit   = r_hit;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_hit   = 1'b0;
                    n_state = i_sts.fill_zero ? S_FIN : S_RD;
                end
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_sts.match) begin
                    n_hit   = 1'b1;
                    n_state = S_FIN;
                end else if (i_sts.last) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_RD;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hit   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_hit   <= n_hit;
        end
    end

    // Commands
    assign o_in_ready    = (r_state == S_IDLE);
    assign o_cmd.load    = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.rd      = (r_state == S_RD);
    assign o_cmd.idx_inc = (r_state == S_CMP) && !i_sts.match && !i_sts.last;
    assign o_cmd.hit     = r_hit;
    assign o_cmd.finish  = (r_state == S_FIN) && i_sts.out_free;

endmodule : alsp_ctrl

`default_nettype wire

### hw/rtl/alsp_checker.sv
// ----------------------------------------------------------------------------
// alsp_checker
// Port-level checks for the allocation size live/peak table, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

module alsp_checker
    import alsp_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_out o_out_data
);

    // Reset drops any pending result
    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // One event at a time: no transfer right after a transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while an event is in flight");

    // Dropped event reports zero counters and no creation
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.table_full |->
            (o_out_data.entry_alloc_total == '0) && (o_out_data.entry_live == '0) &&
            (o_out_data.entry_peak == '0) && !o_out_data.entry_created)
        else $error("table full result carries counters");

    // Peak never below a positive live count
    a_peak_ge_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.entry_live[LIVE_W-1] |->
            o_out_data.entry_peak >= o_out_data.entry_live[PEAK_W-1:0])
        else $error("peak below live count");

endmodule : alsp_checker

bind alloc_size_live_peak_table alsp_checker u_alsp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);

`default_nettype wire
